@@ src/bdmc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the multi-click key debouncer.
package bdmc_pkg;

    localparam int unsigned KEY_PORTS = 4;

    localparam logic [15:0] DEBOUNCE_RESET    = 16'd10;
    localparam logic [15:0] WINDOW_RESET      = 16'd150;
    localparam logic [3:0]  ACTIVE_HIGH_RESET = 4'(32'h1 << 3);
    localparam logic [7:0]  CLICKS_RESET      = 8'd1;
    localparam logic [7:0]  CLICKS_MAX        = 8'd255;

    typedef enum logic [1:0] {
        REG_DEBOUNCE    = 2'd0,
        REG_WINDOW      = 2'd1,
        REG_ACTIVE_HIGH = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [3:0]  key_levels;
        logic [31:0] now_ticks;
        logic [3:0]  clear_mask;
    } scan_item_t;

    typedef struct packed {
        logic [3:0]  pressed_mask;
        logic [3:0]  window_open_mask;
        logic [3:0]  done_mask;
        logic [7:0]  clicks_key0;
        logic [7:0]  clicks_key1;
        logic [7:0]  clicks_key2;
        logic [7:0]  clicks_key3;
        logic [31:0] duration_key0;
        logic [31:0] duration_key1;
        logic [31:0] duration_key2;
        logic [31:0] duration_key3;
    } result_item_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] window_ticks;
    } lane_cfg_t;

    typedef struct packed {
        logic        pressed;
        logic        window;
        logic        done;
        logic [7:0]  clicks;
        logic [31:0] duration;
    } lane_res_t;

endpackage

@@ src/button_debounce_multi_click.sv @@
`timescale 1ns / 1ps
// Multi-click key debouncer, top level.
//
// Each scan transfer on the scan channel carries four raw key levels, a
// millisecond timestamp and a clear mask. Every scan yields exactly one
// result transfer with the debounced pressed, window-open and done masks,
// the click count of each key and its press start or press length.
// One lane per key updates its state in the cycle the scan is accepted,
// and the merged result is registered, so a result appears in the cycle
// after its scan. A scan may be accepted every cycle unless scan_stall is
// high: throughput is one item per cycle while the receiver does not stall.
// The result register holds one item. While it is full and the receiver
// stalls, scan_stall is raised and the held result stays unchanged.
// Configuration writes (debounce ticks, click window ticks, active-high
// mask) are taken at any edge with cfg_we high and should be made while idle.
// Reset restores the register defaults, clears all key state, sets every
// click count to one and empties the result register.
module button_debounce_multi_click
    import bdmc_pkg::*;
#(
    parameter int unsigned NUM_KEYS = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         scan_valid,
    output logic         scan_stall,
    input  scan_item_t   scan,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    logic [15:0] debounce_reg;
    logic [15:0] window_reg;
    logic [3:0]  active_high_reg;

    logic        fire;
    logic [3:0]  active;
    lane_cfg_t   lane_cfg;
    lane_res_t   lane_res [KEY_PORTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RESET;
            window_reg      <= WINDOW_RESET;
            active_high_reg <= ACTIVE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:    debounce_reg    <= cfg_data;
                REG_WINDOW:      window_reg      <= cfg_data;
                REG_ACTIVE_HIGH: active_high_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    assign scan_stall = result_valid && result_stall;
    assign fire       = scan_valid && !scan_stall;
    assign active     = ~(scan.key_levels ^ active_high_reg);

    assign lane_cfg.debounce_ticks = debounce_reg;
    assign lane_cfg.window_ticks   = window_reg;

    for (genvar k = 0; k < KEY_PORTS; k++)
    begin : g_lane
        if (k < NUM_KEYS)
        begin : g_on
            bdmc_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .fire   (fire),
                .active (active[k]),
                .clear  (scan.clear_mask[k]),
                .now    (scan.now_ticks),
                .cfg    (lane_cfg),
                .res    (lane_res[k])
            );
        end
        else
        begin : g_off
            assign lane_res[k] = '0;
        end
    end

    bdmc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .lane_res     (lane_res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ src/bdmc_lane.sv @@
`timescale 1ns / 1ps
// One key lane: timestamp debounce, press timing and click window.
module bdmc_lane
    import bdmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        active,
    input  logic        clear,
    input  logic [31:0] now,
    input  lane_cfg_t   cfg,
    output lane_res_t   res
);

    logic        pressed_reg, pressed_next;
    logic        window_reg, window_next;
    logic        done_reg, done_next;
    logic [31:0] db_start_reg, db_start_next;
    logic [31:0] press_reg, press_next;
    logic [31:0] release_reg, release_next;
    logic [7:0]  clicks_reg, clicks_next;

    logic        want;
    logic        confirm;
    logic        release_now;
    logic        window_end;
    logic [31:0] db_elapsed;
    logic [31:0] win_elapsed;
    logic [7:0]  clicks_base;
    logic        done_base;

    assign want        = pressed_reg ? !active : active;
    assign db_elapsed  = now - db_start_reg;
    assign win_elapsed = now - release_reg;
    assign confirm     = want && (db_start_reg != '0)
                         && (db_elapsed > {16'd0, cfg.debounce_ticks});
    assign release_now = confirm && pressed_reg;
    // A release in this scan restamps the window, so it cannot also end it.
    assign window_end  = window_reg && !release_now
                         && (win_elapsed > {16'd0, cfg.window_ticks});
    assign clicks_base = clear ? CLICKS_RESET : clicks_reg;
    assign done_base   = clear ? 1'b0 : done_reg;

    always_comb
    begin
        db_start_next = db_start_reg;
        if (want)
        begin
            if (db_start_reg == '0)
                db_start_next = now;
            else if (confirm)
                db_start_next = '0;
        end

        pressed_next = confirm ? !pressed_reg : pressed_reg;
        press_next   = press_reg;
        if (confirm)
            press_next = pressed_reg ? (now - press_reg) : now;
        release_next = release_now ? now : release_reg;

        window_next = window_reg || release_now;
        clicks_next = clicks_base;
        done_next   = done_base;
        if (window_end)
        begin
            window_next = 1'b0;
            if (pressed_next)
            begin
                if (clicks_base != CLICKS_MAX)
                    clicks_next = clicks_base + 8'd1;
            end
            else
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg  <= 1'b0;
            window_reg   <= 1'b0;
            done_reg     <= 1'b0;
            db_start_reg <= '0;
            press_reg    <= '0;
            release_reg  <= '0;
            clicks_reg   <= CLICKS_RESET;
        end
        else if (fire)
        begin
            pressed_reg  <= pressed_next;
            window_reg   <= window_next;
            done_reg     <= done_next;
            db_start_reg <= db_start_next;
            press_reg    <= press_next;
            release_reg  <= release_next;
            clicks_reg   <= clicks_next;
        end
    end

    assign res.pressed  = pressed_next;
    assign res.window   = window_next;
    assign res.done     = done_next;
    assign res.clicks   = clicks_next;
    assign res.duration = press_next;

endmodule

@@ src/bdmc_merge.sv @@
`timescale 1ns / 1ps
// Merges the lane results into one result item and holds it in the output register.
module bdmc_merge
    import bdmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  lane_res_t    lane_res [KEY_PORTS],
    input  logic         result_stall,
    output logic         result_valid,
    output result_item_t result
);

    logic         valid_reg;
    result_item_t data_reg;
    result_item_t data_next;

    always_comb
    begin
        for (int k = 0; k < KEY_PORTS; k++)
        begin
            data_next.pressed_mask[k]     = lane_res[k].pressed;
            data_next.window_open_mask[k] = lane_res[k].window;
            data_next.done_mask[k]        = lane_res[k].done;
        end
        data_next.clicks_key0   = lane_res[0].clicks;
        data_next.clicks_key1   = lane_res[1].clicks;
        data_next.clicks_key2   = lane_res[2].clicks;
        data_next.clicks_key3   = lane_res[3].clicks;
        data_next.duration_key0 = lane_res[0].duration;
        data_next.duration_key1 = lane_res[1].duration;
        data_next.duration_key2 = lane_res[2].duration;
        data_next.duration_key3 = lane_res[3].duration;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (fire)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

@@ src/bdmc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the multi-click key debouncer and their binding.
module bdmc_checker
    import bdmc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         scan_valid,
    input logic         scan_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result
);

    // A stalled result stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Every accepted scan shows a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && !scan_stall |=> result_valid)
        else $error("accepted scan gave no result");

    // No scan is taken while a result waits on a stalled receiver.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> scan_stall)
        else $error("scan accepted over a held result");

    // Key 0 always exists and its count never drops below one.
    a_clicks_min: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.clicks_key0 != 8'd0)
        else $error("click count of key 0 is zero");

endmodule

bind button_debounce_multi_click bdmc_checker u_bdmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
